/* hdl/zph_pkg.sv */
//------------------------------------------------------------------------------
// zph_pkg
// Shared types and constants of the Zobrist position hash core.
//------------------------------------------------------------------------------
`default_nettype none

package zph_pkg;

   localparam int KeyTableDepth = 769;
   localparam int Squares       = 64;
   localparam int KeyWidth      = 64;
   localparam int BoardWidth    = Squares;
   localparam int KeyIndexWidth = 10;
   localparam int KeyAddrWidth  = $clog2(KeyTableDepth);
   localparam int SqWidth       = $clog2(Squares);
   localparam int PieceWidth    = 3;
   localparam int SideKeyIndex  = 12 * Squares;

   localparam logic [PieceWidth-1:0] PiecePawn   = 3'd0;
   localparam logic [PieceWidth-1:0] PieceKnight = 3'd1;
   localparam logic [PieceWidth-1:0] PieceBishop = 3'd2;
   localparam logic [PieceWidth-1:0] PieceRook   = 3'd3;
   localparam logic [PieceWidth-1:0] PieceQueen  = 3'd4;
   localparam logic [PieceWidth-1:0] PieceKing   = 3'd5;

   localparam logic ModeKeyWrite = 1'b0;
   localparam logic ModeBoard    = 1'b1;

   typedef enum logic [1:0] {
      GroupPawn   = 2'd0,
      GroupKnight = 2'd1,
      GroupSlider = 2'd2,
      GroupKing   = 2'd3
   } group_type;

   typedef enum logic [1:0] {
      StIdle   = 2'd0,
      StScan   = 2'd1,
      StSide   = 2'd2,
      StSettle = 2'd3
   } state_type;

   typedef struct packed {
      logic absorb;
      logic close;
      logic emit;
   } acc_ctrl_type;

endpackage

`default_nettype wire

/* hdl/zph_ram.sv */
//------------------------------------------------------------------------------
// zph_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module zph_ram #(
   parameter int Width = 64,
   parameter int Depth = 769
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/zph_seq.sv */
//------------------------------------------------------------------------------
// zph_seq
// Square scan sequencer: walks the bitboards one square per cycle and issues
// key reads for the shared xor accumulator.
//------------------------------------------------------------------------------
`default_nettype none

module zph_seq
   import zph_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     req_mode,
   input  wire logic                     req_color,
   input  wire logic [1:0]               req_piece_group,
   input  wire logic [BoardWidth-1:0]    req_board_a,
   input  wire logic [BoardWidth-1:0]    req_board_b,
   input  wire logic                     req_black_to_move,
   input  wire logic                     req_last,
   output logic                          busy,
   output logic                          rd_en,
   output logic [KeyIndexWidth-1:0]      rd_index,
   output acc_ctrl_type                  ctrl
);

   state_type              state_ff, state_in;
   logic [SqWidth-1:0]     sq_ff, sq_in;
   logic [BoardWidth-1:0]  a_ff, a_in;
   logic [BoardWidth-1:0]  b_ff, b_in;
   group_type              group_ff, group_in;
   logic                   color_ff, color_in;
   logic                   black_ff, black_in;
   logic                   last_ff, last_in;
   logic                   pend_ff;
   logic                   accept;
   logic [PieceWidth-1:0]  piece;
   logic                   hit;

   assign busy   = (state_ff != StIdle);
   assign accept = start && !busy && (req_mode == ModeBoard);

   always_comb begin
      piece = PiecePawn;
      hit   = 1'b0;
      unique case (group_ff)
         GroupPawn: begin
            piece = PiecePawn;
            hit   = a_ff[0];
         end
         GroupKnight: begin
            piece = PieceKnight;
            hit   = a_ff[0];
         end
         GroupSlider: begin
            hit = a_ff[0] | b_ff[0];
            unique case ({a_ff[0], b_ff[0]})
               2'b10:   piece = PieceBishop;
               2'b01:   piece = PieceRook;
               2'b11:   piece = PieceQueen;
               default: piece = PiecePawn;
            endcase
         end
         GroupKing: begin
            piece = PieceKing;
            hit   = a_ff[0];
         end
         default: begin
            piece = PiecePawn;
            hit   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= rd_en;
      end
      sq_ff    <= sq_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      group_ff <= group_in;
      color_ff <= color_in;
      black_ff <= black_in;
      last_ff  <= last_in;
   end

   always_comb begin
      state_in    = state_ff;
      sq_in       = sq_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      group_in    = group_ff;
      color_in    = color_ff;
      black_in    = black_ff;
      last_in     = last_ff;
      rd_en       = 1'b0;
      rd_index    = {piece, color_ff, sq_ff};
      ctrl.absorb = pend_ff;
      ctrl.close  = 1'b0;
      ctrl.emit   = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StScan;
               sq_in    = '0;
               a_in     = req_board_a;
               b_in     = req_board_b;
               group_in = group_type'(req_piece_group);
               color_in = req_color;
               black_in = req_black_to_move;
               last_in  = req_last;
            end
         end
         StScan: begin
            rd_en = hit;
            a_in  = a_ff >> 1;
            b_in  = b_ff >> 1;
            sq_in = sq_ff + SqWidth'(1);
            if (sq_ff == SqWidth'(Squares - 1)) begin
               state_in = StSide;
            end
         end
         StSide: begin
            rd_en    = last_ff && black_ff;
            rd_index = KeyIndexWidth'(SideKeyIndex);
            state_in = StSettle;
         end
         StSettle: begin
            ctrl.close = 1'b1;
            ctrl.emit  = last_ff;
            state_in   = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/zph_acc.sv */
//------------------------------------------------------------------------------
// zph_acc
// Shared xor accumulator and result register of the hash core.
//------------------------------------------------------------------------------
`default_nettype none

module zph_acc
   import zph_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire acc_ctrl_type         ctrl,
   input  wire logic [KeyWidth-1:0]  rd_data,
   output logic                      rsp_valid,
   output logic [KeyWidth-1:0]       rsp_signature
);

   logic [KeyWidth-1:0] acc_ff, acc_in;
   logic [KeyWidth-1:0] sum;
   logic                valid_ff, valid_in;
   logic [KeyWidth-1:0] sig_ff, sig_in;

   assign sum = ctrl.absorb ? (acc_ff ^ rd_data) : acc_ff;

   always_comb begin
      acc_in   = sum;
      valid_in = 1'b0;
      sig_in   = sig_ff;
      if (ctrl.close && ctrl.emit) begin
         acc_in   = '0;
         valid_in = 1'b1;
         sig_in   = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
      sig_ff <= sig_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_signature = sig_ff;

endmodule

`default_nettype wire

/* hdl/zobrist_position_hash_core.sv */
//------------------------------------------------------------------------------
// zobrist_position_hash_core
// 64-bit Zobrist signature of a chess position from bitboard words.
//------------------------------------------------------------------------------
// A key write (req_mode 0) goes straight into the key table and busy stays
// low. A bitboard word (req_mode 1) holds busy through the 64-square scan,
// one square per cycle, each reading at most one key from the key table's
// one read port and xoring it into the accumulator, and then through the
// side-to-move step and the settle step; a new bitboard word is taken only
// once busy has fallen. On a word marked last, rsp_valid pulses for one
// cycle, in the first cycle after busy falls; the receiver cannot stall it.
// The key table holds 769 words (index (piece*2+color)*64+square, side key
// at 768), is not cleared by reset and must be loaded before use.
//------------------------------------------------------------------------------
`default_nettype none

module zobrist_position_hash_core
   import zph_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_mode,
   input  wire logic [KeyIndexWidth-1:0]  req_key_index,
   input  wire logic [KeyWidth-1:0]       req_key_value,
   input  wire logic                      req_color,
   input  wire logic [1:0]                req_piece_group,
   input  wire logic [BoardWidth-1:0]     req_board_a,
   input  wire logic [BoardWidth-1:0]     req_board_b,
   input  wire logic                      req_black_to_move,
   input  wire logic                      req_last,
   output logic                           rsp_valid,
   output logic [KeyWidth-1:0]            rsp_signature
);

   logic                       wr_en;
   logic                       rd_en;
   logic [KeyIndexWidth-1:0]   rd_index;
   logic [KeyWidth-1:0]        rd_data;
   acc_ctrl_type               ctrl;

   assign wr_en = start && !busy && (req_mode == ModeKeyWrite)
                  && ({1'b0, req_key_index} < (KeyIndexWidth + 1)'(KeyTableDepth));

   zph_ram #(
      .Width (KeyWidth),
      .Depth (KeyTableDepth)
   ) u_key_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (KeyAddrWidth'(req_key_index)),
      .wr_data (req_key_value),
      .rd_en   (rd_en),
      .rd_addr (KeyAddrWidth'(rd_index)),
      .rd_data (rd_data)
   );

   zph_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_mode          (req_mode),
      .req_color         (req_color),
      .req_piece_group   (req_piece_group),
      .req_board_a       (req_board_a),
      .req_board_b       (req_board_b),
      .req_black_to_move (req_black_to_move),
      .req_last          (req_last),
      .busy              (busy),
      .rd_en             (rd_en),
      .rd_index          (rd_index),
      .ctrl              (ctrl)
   );

   zph_acc u_acc (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_signature (rsp_signature)
   );

endmodule

`default_nettype wire

/* hdl/zph_check.sv */
//------------------------------------------------------------------------------
// zph_check
// Port-level checks of the hash core, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module zph_check
   import zph_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_mode,
   input wire logic rsp_valid
);

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_board_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == ModeBoard)) |=> busy)
      else $error("board word accepted without going busy");

   a_write_free : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == ModeKeyWrite)) |=> !busy)
      else $error("key write made the core busy");

   a_result_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_busy_result : assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(busy)) |-> !rsp_valid)
      else $error("result strobe as a scan starts");

endmodule

bind zobrist_position_hash_core zph_check u_zph_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_mode  (req_mode),
   .rsp_valid (rsp_valid)
);

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the Zobrist position hash core.
//------------------------------------------------------------------------------
// Loads the whole key table, then drives directed and random bitboard words
// through the start/busy port. A local hash model follows every accepted word.
// Each rsp_valid pulse is compared with the oldest predicted signature. The
// sender idles at different rates, and at times it pauses until nothing is
// left in flight.
//------------------------------------------------------------------------------

module tb;
   import zph_pkg::*;

   localparam int CycleLimit  = 600000;
   localparam int SettleTicks = 80;

   typedef struct {
      logic                     mode;
      logic [KeyIndexWidth-1:0] key_index;
      logic [KeyWidth-1:0]      key_value;
      logic                     color;
      group_type                group;
      logic [BoardWidth-1:0]    board_a;
      logic [BoardWidth-1:0]    board_b;
      logic                     black_to_move;
      logic                     last;
   } hash_word_type;

   logic                     clock;
   logic                     reset             = 1'b1;
   logic                     start             = 1'b0;
   logic                     busy;
   logic                     req_mode          = ModeKeyWrite;
   logic [KeyIndexWidth-1:0] req_key_index     = '0;
   logic [KeyWidth-1:0]      req_key_value     = '0;
   logic                     req_color         = 1'b0;
   logic [1:0]               req_piece_group   = GroupPawn;
   logic [BoardWidth-1:0]    req_board_a       = '0;
   logic [BoardWidth-1:0]    req_board_b       = '0;
   logic                     req_black_to_move = 1'b0;
   logic                     req_last          = 1'b0;
   logic                     rsp_valid;
   logic [KeyWidth-1:0]      rsp_signature;

   logic [KeyWidth-1:0] key_mem [0:KeyTableDepth-1];
   logic [KeyWidth-1:0] hash_acc;
   logic [KeyWidth-1:0] signature_queue [$];
   logic [KeyWidth-1:0] expected_signature;
   int                  fail_count;
   int                  word_count;
   int                  signature_count;
   int                  cycle_count;

   zobrist_position_hash_core DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_key_index     (req_key_index),
      .req_key_value     (req_key_value),
      .req_color         (req_color),
      .req_piece_group   (req_piece_group),
      .req_board_a       (req_board_a),
      .req_board_b       (req_board_b),
      .req_black_to_move (req_black_to_move),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_signature     (rsp_signature)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // hash model

   function automatic void fold_squares(input logic [BoardWidth-1:0] board,
                                        input logic [PieceWidth-1:0] piece,
                                        input logic color);
      int base;
      base = (int'(piece) * 2 + int'(color)) * Squares;
      for (int sq = 0; sq < Squares; sq++) begin
         if (board[sq]) begin
            hash_acc ^= key_mem[base + sq];
         end
      end
   endfunction

   function automatic void hash_word(input hash_word_type w);
      if (w.mode == ModeKeyWrite) begin
         if (int'(w.key_index) < KeyTableDepth) begin
            key_mem[w.key_index] = w.key_value;
         end
      end else begin
         case (w.group)
            GroupPawn: begin
               fold_squares(w.board_a, PiecePawn, w.color);
            end
            GroupKnight: begin
               fold_squares(w.board_a, PieceKnight, w.color);
            end
            GroupSlider: begin
               fold_squares(w.board_a & ~w.board_b, PieceBishop, w.color);
               fold_squares(w.board_b & ~w.board_a, PieceRook, w.color);
               fold_squares(w.board_a & w.board_b, PieceQueen, w.color);
            end
            default: begin
               fold_squares(w.board_a, PieceKing, w.color);
            end
         endcase
         if (w.last) begin
            if (w.black_to_move) begin
               hash_acc ^= key_mem[SideKeyIndex];
            end
            signature_queue.push_back(hash_acc);
            hash_acc = '0;
         end
      end
   endfunction

   // word builders

   function automatic logic [63:0] rand_wide();
      return {$urandom, $urandom};
   endfunction

   function automatic hash_word_type key_word(input int index, input logic [63:0] value);
      hash_word_type w;
      w.mode          = ModeKeyWrite;
      w.key_index     = index[KeyIndexWidth-1:0];
      w.key_value     = value;
      w.color         = 1'($urandom_range(0, 1));
      w.group         = group_type'($urandom_range(0, 3));
      w.board_a       = rand_wide();
      w.board_b       = rand_wide();
      w.black_to_move = 1'($urandom_range(0, 1));
      w.last          = 1'($urandom_range(0, 1));
      return w;
   endfunction

   function automatic hash_word_type board_word(input logic color, input group_type group,
                                                input logic [63:0] a, input logic [63:0] b,
                                                input logic black, input logic last);
      hash_word_type w;
      w.mode          = ModeBoard;
      w.key_index     = KeyIndexWidth'($urandom_range(0, 1023));
      w.key_value     = rand_wide();
      w.color         = color;
      w.group         = group;
      w.board_a       = a;
      w.board_b       = b;
      w.black_to_move = black;
      w.last          = last;
      return w;
   endfunction

   function automatic logic [63:0] rand_board();
      logic [63:0] r;
      case ($urandom_range(0, 5))
         0: r = '0;
         1: r = '1;
         2: r = rand_wide();
         3: r = 64'd1 << $urandom_range(0, 63);
         4: r = rand_wide() & rand_wide() & rand_wide();
         default: r = rand_wide() | rand_wide();
      endcase
      return r;
   endfunction

   // handshake

   task automatic send_word(input hash_word_type w);
      req_mode          <= w.mode;
      req_key_index     <= w.key_index;
      req_key_value     <= w.key_value;
      req_color         <= w.color;
      req_piece_group   <= w.group;
      req_board_a       <= w.board_a;
      req_board_b       <= w.board_b;
      req_black_to_move <= w.black_to_move;
      req_last          <= w.last;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      hash_word(w);
      word_count++;
   endtask

   task automatic idle_gap(input int idle_pct);
      int gap;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      while (signature_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (signature_queue.size() == 0) begin
            $error("signature: expected none, actual %h", rsp_signature);
            fail_count++;
         end else begin
            expected_signature = signature_queue.pop_front();
            signature_count++;
            if (rsp_signature !== expected_signature) begin
               $error("signature: expected %h, actual %h", expected_signature, rsp_signature);
               fail_count++;
            end
         end
      end
   end

   // tests

   task automatic test_key_load();
      logic [63:0] value;
      for (int idx = 0; idx < KeyTableDepth; idx++) begin
         value = (idx == 0) ? '1 : (idx == 1) ? '0 : rand_wide();
         send_word(key_word(idx, value));
      end
      // beyond the table, must not land anywhere
      send_word(key_word(KeyTableDepth, '1));
      send_word(key_word(1023, '1));
   endtask

   task automatic test_empty_position();
      send_word(board_word(1'b0, GroupPawn, '0, '0, 1'b0, 1'b1));
      send_word(board_word(1'b1, GroupKing, '0, '0, 1'b1, 1'b1));
   endtask

   task automatic test_each_group();
      for (int g = 0; g < 4; g++) begin
         for (int c = 0; c < 2; c++) begin
            send_word(board_word(c[0], group_type'(g), '1, '0, c[0], 1'b1));
         end
      end
   endtask

   task automatic test_slider_overlap();
      send_word(board_word(1'b0, GroupSlider, '0, '1, 1'b0, 1'b1));
      send_word(board_word(1'b1, GroupSlider, '1, '1, 1'b0, 1'b1));
      send_word(board_word(1'b0, GroupSlider, 64'h00FF_00FF_F0F0_1234,
                           64'h0F0F_FF00_FF00_8421, 1'b1, 1'b1));
   endtask

   task automatic test_unused_board_b();
      send_word(board_word(1'b1, GroupKnight, 64'h8000_0000_0000_0001, '1, 1'b0, 1'b1));
   endtask

   task automatic test_split_position();
      send_word(board_word(1'b0, GroupPawn, 64'h0000_0000_0000_FF00, '0, 1'b1, 1'b0));
      send_word(key_word(10, rand_wide()));
      send_word(key_word(900, rand_wide()));
      send_word(board_word(1'b1, GroupPawn, 64'h00FF_0000_0000_0000, '0, 1'b1, 1'b1));
   endtask

   task automatic test_drain_pause();
      send_word(board_word(1'b0, GroupKing, 64'h10, '0, 1'b0, 1'b0));
      send_word(board_word(1'b1, GroupKing, 64'h1000_0000_0000_0000, '0, 1'b1, 1'b1));
      wait_drain();
      send_word(board_word(1'b0, GroupSlider, rand_wide(), rand_wide(), 1'b1, 1'b1));
   endtask

   task automatic test_random_positions(input int words, input int idle_pct);
      int          sent;
      int          len;
      logic [63:0] a;
      logic [63:0] b;
      group_type   group;
      sent = 0;
      while (sent < words) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
         for (int k = 0; k < len; k++) begin
            idle_gap(idle_pct);
            if ($urandom_range(0, 9) == 0) begin
               send_word(key_word($urandom_range(0, 1023), rand_wide()));
               sent++;
               idle_gap(idle_pct);
            end
            group = group_type'($urandom_range(0, 3));
            a = rand_board();
            if (group == GroupSlider) begin
               case ($urandom_range(0, 3))
                  0: b = rand_board();
                  1: b = a;
                  2: b = a ^ rand_board();
                  default: b = rand_board() & ~a;
               endcase
            end else begin
               b = rand_wide();
            end
            send_word(board_word(1'($urandom_range(0, 1)), group, a, b,
                                 1'($urandom_range(0, 1)), k == len - 1));
            sent++;
         end
         if ($urandom_range(0, 24) == 0) begin
            wait_drain();
         end
      end
   endtask

   initial begin
      hash_acc        = '0;
      fail_count      = 0;
      word_count      = 0;
      signature_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_key_load();
      test_empty_position();
      test_each_group();
      test_slider_overlap();
      test_unused_board_b();
      test_split_position();
      test_drain_pause();
      test_random_positions(40, 12);
      test_random_positions(40, 66);
      test_random_positions(40, 0);

      wait_drain();
      repeat (SettleTicks) @(posedge clock);

      $display("sent %0d words incl. full key table load, checked %0d signatures",
               word_count, signature_count);
      $display("all piece groups, both colors, slider overlaps, mid-position key writes");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
